// ----- rtl/dlf_pkg.sv -----
// dlf_pkg: shared types and constants for the dense layer forward block.
// Used by dlf_front, dlf_back and dense_layer_forward_relu; no dependencies.
package dlf_pkg;

	// default sizes
	localparam int MAX_OUTPUTS = 64;
	localparam int MAX_INPUTS  = 64;
	localparam int VALUE_WIDTH = 16;

	// fixed field widths
	localparam int REQ_WIDTH       = 2;
	localparam int INDEX_WIDTH     = 6;
	localparam int COUNT_WIDTH     = 7;
	localparam int CFG_INDEX_WIDTH = 1;
	localparam int CFG_DATA_WIDTH  = 7;

	// arithmetic
	localparam int ACC_WIDTH = 40;
	localparam int FRAC_BITS = 8;

	// command queue between front and back, power of two
	localparam int QUEUE_DEPTH = 4;

	// request type codes
	localparam logic [REQ_WIDTH-1:0] REQ_WEIGHT = 2'd0;
	localparam logic [REQ_WIDTH-1:0] REQ_BIAS   = 2'd1;
	localparam logic [REQ_WIDTH-1:0] REQ_ACT    = 2'd2;

	// configuration register indexes
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_OUTPUT_COUNT = 1'b0;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RELU_ENABLE  = 1'b1;

	localparam int OUTPUT_COUNT_RESET = 64;

	typedef enum logic [1:0] {
		OP_WLOAD,
		OP_BLOAD,
		OP_MAC
	} op_t;

	// control of the command at the head of the queue
	typedef struct packed {
		logic valid;
		op_t  op;
		logic last;
	} head_t;

endpackage

// ----- rtl/dlf_ram.sv -----
// dlf_ram: generic single write port, single read port RAM with registered read.
// No dependencies.
module dlf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/dlf_front.sv -----
// dlf_front: takes requests, drops the ones that do nothing, and queues the rest.
// Depends on dlf_pkg.
module dlf_front #(
	parameter int MAX_OUTPUTS = dlf_pkg::MAX_OUTPUTS,
	parameter int MAX_INPUTS  = dlf_pkg::MAX_INPUTS,
	parameter int VALUE_WIDTH = dlf_pkg::VALUE_WIDTH,
	localparam int OW = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1,
	localparam int IW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [dlf_pkg::REQ_WIDTH-1:0]       req_type,
	input  logic [dlf_pkg::INDEX_WIDTH-1:0]     row,
	input  logic [dlf_pkg::INDEX_WIDTH-1:0]     col,
	input  logic signed [VALUE_WIDTH-1:0]       value,
	input  logic                                last,
	input  logic                                pop,
	output dlf_pkg::head_t                      head,
	output logic [OW-1:0]                       head_row,
	output logic [IW-1:0]                       head_col,
	output logic signed [VALUE_WIDTH-1:0]       head_value
);

	localparam int QD = dlf_pkg::QUEUE_DEPTH;
	localparam int QA = $clog2(QD);

	dlf_pkg::op_t               op_q    [QD];
	logic [OW-1:0]              row_q   [QD];
	logic [IW-1:0]              col_q   [QD];
	logic signed [VALUE_WIDTH-1:0] value_q [QD];
	logic                       last_q  [QD];

	logic [QA:0]   wr_ptr_q;
	logic [QA:0]   rd_ptr_q;
	logic          full;
	logic          empty;
	logic          push;
	logic          keep;
	dlf_pkg::op_t  op_in;
	logic          row_ok;
	logic          col_ok;
	logic [31:0]   row_ext;
	logic [31:0]   col_ext;

	assign row_ext = 32'(row);
	assign col_ext = 32'(col);
	assign row_ok  = row_ext < 32'(MAX_OUTPUTS);
	assign col_ok  = col_ext < 32'(MAX_INPUTS);

	always_comb begin
		case (req_type)
			dlf_pkg::REQ_WEIGHT: begin
				keep  = row_ok && col_ok;
				op_in = dlf_pkg::OP_WLOAD;
			end
			dlf_pkg::REQ_BIAS: begin
				keep  = row_ok;
				op_in = dlf_pkg::OP_BLOAD;
			end
			dlf_pkg::REQ_ACT: begin
				keep  = col_ok;
				op_in = dlf_pkg::OP_MAC;
			end
			default: begin
				keep  = 1'b0;
				op_in = dlf_pkg::OP_MAC;
			end
		endcase
	end

	assign empty = (wr_ptr_q == rd_ptr_q);
	assign full  = (wr_ptr_q[QA] != rd_ptr_q[QA]) && (wr_ptr_q[QA-1:0] == rd_ptr_q[QA-1:0]);
	assign busy  = full;
	assign push  = start && !full && keep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			op_q[wr_ptr_q[QA-1:0]]    <= op_in;
			row_q[wr_ptr_q[QA-1:0]]   <= row_ext[OW-1:0];
			col_q[wr_ptr_q[QA-1:0]]   <= col_ext[IW-1:0];
			value_q[wr_ptr_q[QA-1:0]] <= value;
			last_q[wr_ptr_q[QA-1:0]]  <= last;
		end
	end

	assign head.valid = !empty;
	assign head.op    = op_q[rd_ptr_q[QA-1:0]];
	assign head.last  = last_q[rd_ptr_q[QA-1:0]];
	assign head_row   = row_q[rd_ptr_q[QA-1:0]];
	assign head_col   = col_q[rd_ptr_q[QA-1:0]];
	assign head_value = value_q[rd_ptr_q[QA-1:0]];

endmodule

// ----- rtl/dlf_back.sv -----
// dlf_back: executes queued commands: store loads, the multiply-accumulate sweep
// over all neurons, and the output sweep. Depends on dlf_pkg and dlf_ram.
module dlf_back #(
	parameter int MAX_OUTPUTS = dlf_pkg::MAX_OUTPUTS,
	parameter int MAX_INPUTS  = dlf_pkg::MAX_INPUTS,
	parameter int VALUE_WIDTH = dlf_pkg::VALUE_WIDTH,
	localparam int OW = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1,
	localparam int IW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dlf_pkg::head_t                      head,
	input  logic [OW-1:0]                       head_row,
	input  logic [IW-1:0]                       head_col,
	input  logic signed [VALUE_WIDTH-1:0]       head_value,
	output logic                                pop,
	input  logic [dlf_pkg::COUNT_WIDTH-1:0]     output_count,
	input  logic                                relu_enable,
	output logic                                result_valid,
	output logic [dlf_pkg::INDEX_WIDTH-1:0]     out_index,
	output logic signed [VALUE_WIDTH-1:0]       out_value,
	output logic                                out_last
);

	localparam int VW    = VALUE_WIDTH;
	localparam int ACCW  = dlf_pkg::ACC_WIDTH;
	localparam int FRAC  = dlf_pkg::FRAC_BITS;
	localparam int SW    = ACCW + 2;
	localparam int QW    = SW - FRAC;
	localparam int CW    = $clog2(MAX_OUTPUTS + 1);
	localparam int WDEP  = 1 << (OW + IW);
	localparam int ROUND = 1 << (FRAC - 1);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_MAC   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t state_q;
	logic [OW-1:0]          r_q;
	logic [IW-1:0]          col_q;
	logic signed [VW-1:0]   value_q;
	logic                   last_q;
	logic                   fresh_q;   // accumulators hold zero, not yet written this vector

	logic [CW-1:0]          cnt;
	logic                   r_last_mac;
	logic                   r_last_emit;
	logic                   issue_mac;
	logic                   issue_emit;

	logic                   mac_v_s1;
	logic                   mac_v_s2;
	logic                   emit_v_s1;
	logic                   emit_v_s2;
	logic [OW-1:0]          r_s1;
	logic [OW-1:0]          r_s2;
	logic                   emit_last_s1;
	logic                   emit_last_s2;
	logic signed [2*VW-1:0] prod_s2;
	logic [ACCW-1:0]        acc_s2;
	logic signed [SW-1:0]   sum_s2;

	logic                   result_valid_q;
	logic [dlf_pkg::INDEX_WIDTH-1:0] out_index_q;
	logic signed [VW-1:0]   out_value_q;
	logic                   out_last_q;

	logic                   w_we;
	logic [VW-1:0]          w_rdata;
	logic                   b_we;
	logic [VW-1:0]          b_rdata;
	logic                   a_we;
	logic [ACCW-1:0]        a_wdata;
	logic [ACCW-1:0]        a_rdata;
	logic [ACCW-1:0]        prod_ext;

	logic signed [QW-1:0]   q;
	logic [QW-VW:0]         q_hi;
	logic signed [VW-1:0]   q_sat;
	logic signed [VW-1:0]   q_out;
	logic [31:0]            r_s2_ext;

	always_comb begin
		if (32'(output_count) > 32'(MAX_OUTPUTS)) begin
			cnt = CW'(MAX_OUTPUTS);
		end else begin
			cnt = CW'(output_count);
		end
	end

	assign r_last_mac  = (r_q == OW'(MAX_OUTPUTS - 1));
	assign r_last_emit = (32'(r_q) + 32'd1 == 32'(cnt));
	assign issue_mac   = (state_q == ST_MAC);
	assign issue_emit  = (state_q == ST_EMIT);
	assign pop         = head.valid && (state_q == ST_IDLE);

	assign w_we = pop && (head.op == dlf_pkg::OP_WLOAD);
	assign b_we = pop && (head.op == dlf_pkg::OP_BLOAD);

	// weights laid out as {row, col}
	dlf_ram #(.WIDTH(VW), .DEPTH(WDEP)) u_weight_ram (
		.clk   (clk),
		.we    (w_we),
		.waddr ({head_row, head_col}),
		.wdata (head_value),
		.raddr ({r_q, col_q}),
		.rdata (w_rdata)
	);

	dlf_ram #(.WIDTH(VW), .DEPTH(MAX_OUTPUTS)) u_bias_ram (
		.clk   (clk),
		.we    (b_we),
		.waddr (head_row),
		.wdata (head_value),
		.raddr (r_q),
		.rdata (b_rdata)
	);

	assign prod_ext = ACCW'(prod_s2);
	assign a_we     = mac_v_s2;
	assign a_wdata  = fresh_q ? prod_ext : acc_s2 + prod_ext;

	dlf_ram #(.WIDTH(ACCW), .DEPTH(MAX_OUTPUTS)) u_acc_ram (
		.clk   (clk),
		.we    (a_we),
		.waddr (r_s2),
		.wdata (a_wdata),
		.raddr (r_q),
		.rdata (a_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			r_q     <= '0;
			fresh_q <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop && head.op == dlf_pkg::OP_MAC) begin
						state_q <= ST_MAC;
						r_q     <= '0;
					end
				end
				ST_MAC: begin
					r_q <= r_q + 1'b1;
					if (r_last_mac) begin
						state_q <= ST_DRAIN;
						r_q     <= '0;
					end
				end
				ST_DRAIN: begin
					// wait for the last accumulator write-back
					if (!mac_v_s1 && !mac_v_s2) begin
						if (last_q && cnt != '0) begin
							fresh_q <= 1'b0;
							state_q <= ST_EMIT;
						end else begin
							fresh_q <= last_q;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_EMIT: begin
					r_q <= r_q + 1'b1;
					if (r_last_emit) begin
						r_q     <= '0;
						fresh_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.op == dlf_pkg::OP_MAC) begin
			col_q   <= head_col;
			value_q <= head_value;
			last_q  <= head.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_v_s1       <= 1'b0;
			mac_v_s2       <= 1'b0;
			emit_v_s1      <= 1'b0;
			emit_v_s2      <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			mac_v_s1       <= issue_mac;
			mac_v_s2       <= mac_v_s1;
			emit_v_s1      <= issue_emit;
			emit_v_s2      <= emit_v_s1;
			result_valid_q <= emit_v_s2;
		end
	end

	always_ff @(posedge clk) begin
		r_s1         <= r_q;
		r_s2         <= r_s1;
		emit_last_s1 <= r_last_emit;
		emit_last_s2 <= emit_last_s1;
		prod_s2      <= $signed(w_rdata) * value_q;
		acc_s2       <= a_rdata;
		sum_s2       <= SW'($signed(a_rdata)) + (SW'($signed(b_rdata)) <<< FRAC) + SW'(ROUND);
		out_index_q  <= r_s2_ext[dlf_pkg::INDEX_WIDTH-1:0];
		out_value_q  <= q_out;
		out_last_q   <= emit_last_s2;
	end

	// floor shift gives round half up after the added half LSB
	assign q        = QW'(sum_s2 >>> FRAC);
	assign q_hi     = q[QW-1:VW-1];
	assign r_s2_ext = 32'(r_s2);

	always_comb begin
		if (!q[QW-1] && (|q_hi)) begin
			q_sat = {1'b0, {(VW-1){1'b1}}};
		end else if (q[QW-1] && !(&q_hi)) begin
			q_sat = {1'b1, {(VW-1){1'b0}}};
		end else begin
			q_sat = q[VW-1:0];
		end
		if (relu_enable && q_sat[VW-1]) begin
			q_out = '0;
		end else begin
			q_out = q_sat;
		end
	end

	assign result_valid = result_valid_q;
	assign out_index    = out_index_q;
	assign out_value    = out_value_q;
	assign out_last     = out_last_q;

endmodule

// ----- rtl/dense_layer_forward_relu.sv -----
// Fully connected layer forward pass with optional ReLU, Q8.8 data, 40-bit sums.
// Loads are written to the weight or bias RAM; an activation sweeps all MAX_OUTPUTS neurons, one
// neuron per cycle through the shared multiply-accumulate and accumulator RAM port.
// On a last activation, min(output_count, MAX_OUTPUTS) results follow, one per
// cycle, after the sweep's last neuron. Results cannot be stalled. Reset clears control
// and config to defaults; weight and bias RAMs keep their contents, accumulators read as zero.
module dense_layer_forward_relu #(
	parameter int MAX_OUTPUTS = dlf_pkg::MAX_OUTPUTS,
	parameter int MAX_INPUTS  = dlf_pkg::MAX_INPUTS,
	parameter int VALUE_WIDTH = dlf_pkg::VALUE_WIDTH
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [dlf_pkg::REQ_WIDTH-1:0]         req_type,
	input  logic [dlf_pkg::INDEX_WIDTH-1:0]       row,
	input  logic [dlf_pkg::INDEX_WIDTH-1:0]       col,
	input  logic signed [VALUE_WIDTH-1:0]         value,
	input  logic                                  last,
	output logic                                  result_valid,
	output logic [dlf_pkg::INDEX_WIDTH-1:0]       out_index,
	output logic signed [VALUE_WIDTH-1:0]         out_value,
	output logic                                  out_last,
	input  logic                                  cfg_we,
	input  logic [dlf_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
	input  logic [dlf_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);

	localparam int OW = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
	localparam int IW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;

	logic [dlf_pkg::COUNT_WIDTH-1:0] output_count_q;
	logic                            relu_enable_q;

	dlf_pkg::head_t              head;
	logic [OW-1:0]               head_row;
	logic [IW-1:0]               head_col;
	logic signed [VALUE_WIDTH-1:0] head_value;
	logic                        pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_count_q <= dlf_pkg::COUNT_WIDTH'(dlf_pkg::OUTPUT_COUNT_RESET);
			relu_enable_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				dlf_pkg::CFG_OUTPUT_COUNT: begin
					output_count_q <= cfg_data[dlf_pkg::COUNT_WIDTH-1:0];
				end
				dlf_pkg::CFG_RELU_ENABLE: begin
					relu_enable_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	dlf_front #(
		.MAX_OUTPUTS (MAX_OUTPUTS),
		.MAX_INPUTS  (MAX_INPUTS),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.row        (row),
		.col        (col),
		.value      (value),
		.last       (last),
		.pop        (pop),
		.head       (head),
		.head_row   (head_row),
		.head_col   (head_col),
		.head_value (head_value)
	);

	dlf_back #(
		.MAX_OUTPUTS (MAX_OUTPUTS),
		.MAX_INPUTS  (MAX_INPUTS),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.head_row     (head_row),
		.head_col     (head_col),
		.head_value   (head_value),
		.pop          (pop),
		.output_count (output_count_q),
		.relu_enable  (relu_enable_q),
		.result_valid (result_valid),
		.out_index    (out_index),
		.out_value    (out_value),
		.out_last     (out_last)
	);

endmodule
